// ===== hdl/sha1de_pkg.sv =====
// sha1de_pkg: shared types, constants and round helpers for the SHA-1 digest engine.
// No dependencies; used by every module of the engine.
package sha1de_pkg;

	// Input item as it arrives on the item channel
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       end_of_message;
	} sha1de_in_t;

	// One digest word as it leaves on the digest channel
	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} sha1de_out_t;

	// Commands from the message sequencer to the compression unit
	typedef struct packed {
		logic start;  // load block and chain, run 80 rounds
		logic init;   // reload chain with the initial values
	} sha1de_cmd_t;

	localparam logic [4:0][31:0] SHA1_IV = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_STAGE0 = 32'h5A827999;
	localparam logic [31:0] K_STAGE1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_STAGE2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_STAGE3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_BYTE      = 8'h80;
	localparam logic [7:0] ZERO_BYTE     = 8'h00;
	localparam logic [6:0] LAST_ROUND    = 7'd79;
	localparam logic [2:0] LAST_WORD_IDX = 3'd4;
	localparam logic [5:0] LEN_START_POS = 6'd56;
	localparam logic [5:0] BLOCK_END_POS = 6'd63;

	function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

	// Round function plus round constant, chosen by round number
	function automatic logic [31:0] sha1de_fk(input logic [6:0] t, input logic [31:0] b,
		input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		logic [31:0] k;
		if (t < 7'd20) begin
			f = (b & c) | (~b & d);
			k = K_STAGE0;
		end else if (t < 7'd40) begin
			f = b ^ c ^ d;
			k = K_STAGE1;
		end else if (t < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
			k = K_STAGE2;
		end else begin
			f = b ^ c ^ d;
			k = K_STAGE3;
		end
		return f + k;
	endfunction

endpackage

// ===== hdl/sha1_digest_engine.sv =====
// sha1_digest_engine: streaming SHA-1 hasher over sha1de_front, sha1de_back, sha1de_compress.
// Item to sequencer: through the registered input queue; one byte item per cycle between blocks.
// A full block holds the sequencer in S_WAIT (start, load, 80 rounds, final add, done), taking
// no bytes. End of message: padding at one byte per cycle outside compression (one more block
// when fill > 55), eight length bytes, one compression, five words at one per cycle unless
// stalled. Reset: asynchronous, clears control and loads the initial chain; buffer uncleared.
module sha1_digest_engine #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  sha1de_pkg::sha1de_in_t  item,
	output logic                    digest_valid,
	input  logic                    digest_stall,
	output sha1de_pkg::sha1de_out_t digest
);

	logic                    q_valid;
	sha1de_pkg::sha1de_in_t  q_item;
	logic                    q_pop;
	sha1de_pkg::sha1de_cmd_t cmd;
	logic [15:0][31:0]       block;
	logic                    done;
	logic [4:0][31:0]        chain;

	// Front: accept and queue items
	sha1de_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// Back: message sequencing and digest output
	sha1de_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.cmd          (cmd),
		.block        (block),
		.done         (done),
		.chain        (chain),
		.digest_valid (digest_valid),
		.digest_stall (digest_stall),
		.digest       (digest)
	);

	// Compression unit
	sha1de_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.block  (block),
		.done   (done),
		.chain  (chain)
	);

endmodule

// ===== hdl/sha1de_front.sv =====
// sha1de_front: accepts input items, drops those with neither byte nor end,
// and queues the rest for the message sequencer. Depends on sha1de_pkg.
module sha1de_front #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  sha1de_pkg::sha1de_in_t item,
	output logic                   q_valid,
	output sha1de_pkg::sha1de_in_t q_item,
	input  logic                   q_pop
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	sha1de_pkg::sha1de_in_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	// Only items that change state are queued
	assign item_stall = (cnt_q == CW'(DEPTH));
	assign push = item_valid && !item_stall && (item.byte_valid || item.end_of_message);
	assign pop = q_pop && q_valid;
	assign q_valid = (cnt_q != '0);
	assign q_item = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> !pop)
		else $error("front queue popped while empty");

endmodule

// ===== hdl/sha1de_compress.sv =====
// sha1de_compress: SHA-1 compression unit, one round per cycle over a rolling
// 16-word schedule window; holds the chaining words. Depends on sha1de_pkg.
module sha1de_compress (
	input  logic                    clk,
	input  logic                    arst_n,
	input  sha1de_pkg::sha1de_cmd_t cmd,
	input  logic [15:0][31:0]       block,
	output logic                    done,
	output logic [4:0][31:0]        chain
);

	logic [4:0][31:0]  h_q;
	logic [4:0][31:0]  work_q;
	logic [15:0][31:0] sch_q;
	logic [6:0]        rnd_q;
	logic              busy_q;
	logic              fin_q;
	logic              done_q;
	logic [31:0]       tmp;
	logic [31:0]       w_next;

	assign done = done_q;
	assign chain = h_q;

	// One round: a' = rol5(a) + f + k + e + w
	assign tmp = sha1de_pkg::rol(work_q[0], 5)
		+ sha1de_pkg::sha1de_fk(rnd_q, work_q[1], work_q[2], work_q[3])
		+ work_q[4] + sch_q[0];
	assign w_next = sha1de_pkg::rol(sch_q[13] ^ sch_q[8] ^ sch_q[2] ^ sch_q[0], 1);

	// Round counter, chaining words and completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q <= sha1de_pkg::SHA1_IV;
			rnd_q <= '0;
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= fin_q;
			fin_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 1'b1;
				if (rnd_q == sha1de_pkg::LAST_ROUND) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				for (int i = 0; i < 5; i++) begin
					h_q[i] <= h_q[i] + work_q[i];
				end
			end else if (cmd.init) begin
				h_q <= sha1de_pkg::SHA1_IV;
			end
		end
	end

	// Working variables and schedule window
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			work_q <= h_q;
			sch_q <= block;
		end else if (busy_q) begin
			work_q[0] <= tmp;
			work_q[1] <= work_q[0];
			work_q[2] <= sha1de_pkg::rol(work_q[1], 30);
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3];
			for (int i = 0; i < 15; i++) begin
				sch_q[i] <= sch_q[i + 1];
			end
			sch_q[15] <= w_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (!busy_q && !fin_q))
		else $error("compression started while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> ##1 done_q)
		else $error("final add not followed by done");

endmodule

// ===== hdl/sha1de_back.sv =====
// sha1de_back: message sequencer; packs bytes into the block buffer, pads,
// appends the length, drives the compressor and emits digest words.
// Depends on sha1de_pkg.
module sha1de_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_valid,
	input  sha1de_pkg::sha1de_in_t   q_item,
	output logic                     q_pop,
	output sha1de_pkg::sha1de_cmd_t  cmd,
	output logic [15:0][31:0]        block,
	input  logic                     done,
	input  logic [4:0][31:0]         chain,
	output logic                     digest_valid,
	input  logic                     digest_stall,
	output sha1de_pkg::sha1de_out_t  digest
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PAD  = 5'b00010,
		S_LEN  = 5'b00100,
		S_WAIT = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t                  state_q;
	state_t                  ret_q;
	logic [15:0][3:0][7:0]   blk_q;
	logic [5:0]              fill_q;
	logic [63:0]             bits_q;
	logic                    pad_first_q;
	logic                    go_q;
	logic [2:0]              word_q;
	logic                    out_valid_q;
	sha1de_pkg::sha1de_out_t out_q;
	logic                    wr_en;
	logic [7:0]              wr_byte;
	logic                    blk_full;
	logic                    out_load;
	logic                    out_last;
	logic [63:0]             len_shifted;

	assign block = blk_q;
	assign digest_valid = out_valid_q;
	assign digest = out_q;

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || !digest_stall);
	assign out_last = (word_q == sha1de_pkg::LAST_WORD_IDX);
	assign cmd.start = go_q;
	assign cmd.init = out_load && out_last;

	// Length byte: position 56 carries the top byte
	assign len_shifted = bits_q >> {~fill_q[2:0], 3'b000};

	// Byte source for the block buffer
	always_comb begin
		wr_en = 1'b0;
		wr_byte = sha1de_pkg::ZERO_BYTE;
		case (state_q)
			S_IDLE: begin
				wr_en = q_pop && q_item.byte_valid;
				wr_byte = q_item.data_byte;
			end
			S_PAD: begin
				wr_en = 1'b1;
				wr_byte = pad_first_q ? sha1de_pkg::PAD_BYTE : sha1de_pkg::ZERO_BYTE;
			end
			S_LEN: begin
				wr_en = 1'b1;
				wr_byte = len_shifted[7:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign blk_full = wr_en && (fill_q == sha1de_pkg::BLOCK_END_POS);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q <= S_IDLE;
			fill_q <= '0;
			bits_q <= '0;
			pad_first_q <= 1'b1;
			go_q <= 1'b0;
			word_q <= '0;
		end else begin
			go_q <= 1'b0;
			if (wr_en) begin
				fill_q <= fill_q + 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_item.byte_valid) begin
							bits_q <= bits_q + 64'd8;
						end
						if (blk_full) begin
							go_q <= 1'b1;
							state_q <= S_WAIT;
							ret_q <= q_item.end_of_message ? S_PAD : S_IDLE;
						end else if (q_item.end_of_message) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pad_first_q <= 1'b0;
					if (fill_q == sha1de_pkg::LEN_START_POS - 6'd1) begin
						state_q <= S_LEN;
					end else if (blk_full) begin
						go_q <= 1'b1;
						state_q <= S_WAIT;
						ret_q <= S_PAD;
					end
				end
				S_LEN: begin
					if (blk_full) begin
						go_q <= 1'b1;
						state_q <= S_WAIT;
						ret_q <= S_OUT;
						word_q <= '0;
					end
				end
				S_WAIT: begin
					if (done) begin
						state_q <= ret_q;
					end
				end
				S_OUT: begin
					if (out_load) begin
						word_q <= word_q + 1'b1;
						if (out_last) begin
							bits_q <= '0;
							pad_first_q <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!digest_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload and block buffer, big-endian byte lanes
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.digest_word <= chain[word_q];
			out_q.word_index <= word_q;
			out_q.last_word <= out_last;
		end
		if (wr_en) begin
			blk_q[fill_q[5:2]][~fill_q[1:0]] <= wr_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WAIT) |-> (fill_q == '0))
		else $error("compression running on a partial block");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN) |-> (fill_q[5:3] == 3'b111))
		else $error("length written outside the last eight bytes");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last_word) |-> (out_q.word_index == sha1de_pkg::LAST_WORD_IDX))
		else $error("last flag on a word other than the fifth");

endmodule
